// ===== rtl/rtal_pkg.sv =====
package rtal_pkg;

   localparam int unsigned DEFAULT_ENTRIES = 256;

   localparam int unsigned CODE_W  = 32;
   localparam int unsigned ALPHA_W = 8;
   localparam int unsigned PCT_W   = 7;
   localparam int unsigned WORD_W  = 2 * CODE_W + ALPHA_W;

   localparam logic [1:0] OP_CLEAR  = 2'd0;
   localparam logic [1:0] OP_APPEND = 2'd1;
   localparam logic [1:0] OP_LOOKUP = 2'd2;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_DUP  = 2'd2;
   localparam logic [1:0] ST_MISS = 2'd3;

   localparam logic [1:0] REG_ENABLE  = 2'd0;
   localparam logic [1:0] REG_QUARTER = 2'd1;
   localparam logic [1:0] REG_HALF    = 2'd2;

   localparam logic [PCT_W-1:0] QUARTER_RESET = 7'd25;
   localparam logic [PCT_W-1:0] HALF_RESET    = 7'd50;
   localparam logic [PCT_W-1:0] PCT_MAX       = 7'd100;

   // 2.55 * 2^19, rounded up; exact floor for every percentage up to 100.
   localparam logic [20:0] SCALE_RECIP = 21'd1336935;

   typedef struct packed {
      logic [ALPHA_W-1:0] alpha;
      logic [1:0]         status;
   } result_type;

   function automatic logic [ALPHA_W-1:0] code_to_alpha(
      input logic [ALPHA_W-1:0] code,
      input logic [PCT_W-1:0]   quarter,
      input logic [PCT_W-1:0]   half
   );
      logic [PCT_W-1:0] pct;
      logic [27:0]      prod;
      pct = 7'd0;
      if (code == 8'd1) begin
         pct = PCT_MAX - ((quarter > PCT_MAX) ? PCT_MAX : quarter);
      end else if (code == 8'd2) begin
         pct = (half > PCT_MAX) ? PCT_MAX : half;
      end
      prod = 28'(pct) * 28'(SCALE_RECIP);
      return prod[26:19];
   endfunction

endpackage

// ===== rtl/range_table_alpha_lookup.sv =====
// Range table with a blend alpha per range, searched by binary search.
//
// The req stream carries one word per command: tuser is the operation (clear,
// append, lookup) and tdata packs range_start, range_end, alpha_code and
// lookup_value from the lowest bit up. Every command yields exactly one rsp
// word: tdata is the alpha, tuser the status (done/hit, full, duplicate, miss).
// Ranges must be appended in ascending order of start code.
//
// A clear or an unused operation goes from accept straight to the result, an
// append makes one table read for the duplicate check, then the write, and a
// lookup makes at most ceil(log2(ENTRIES+1)) probes. The probe loop is paced
// by the registered read port of the table memory. One command is in flight
// at a time; the next is taken as soon as the result has moved to the output
// register, even while that register waits on rsp_tready.
//
// Reset empties the table and sets the registers to blend off, 25 and 50
// percent. The table memory itself is not cleared and needs no sweep.
module range_table_alpha_lookup #(
   parameter int unsigned ENTRIES = rtal_pkg::DEFAULT_ENTRIES
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [103:0]                      req_tdata,  // range_start, range_end,
                                                         // alpha_code, lookup_value
   input  logic [1:0]                        req_tuser,  // op
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [7:0]                        rsp_tdata,  // alpha
   output logic [1:0]                        rsp_tuser,  // status
   input  logic                              csr_we,
   input  logic [1:0]                        csr_addr,
   input  logic [rtal_pkg::PCT_W-1:0]        csr_wdata
);

   localparam int unsigned IW = $clog2(ENTRIES);

   logic                              blend_ff;
   logic [rtal_pkg::PCT_W-1:0]        quarter_ff;
   logic [rtal_pkg::PCT_W-1:0]        half_ff;

   logic [rtal_pkg::CODE_W-1:0]       range_start;
   logic [rtal_pkg::CODE_W-1:0]       range_end;
   logic [rtal_pkg::ALPHA_W-1:0]      alpha_code;
   logic [rtal_pkg::CODE_W-1:0]       lookup_value;
   logic [rtal_pkg::ALPHA_W-1:0]      alpha_value;

   logic [IW-1:0]                     rd_addr;
   logic [rtal_pkg::WORD_W-1:0]       rd_data;
   logic                              wr_en;
   logic [IW-1:0]                     wr_addr;
   logic [rtal_pkg::WORD_W-1:0]       wr_data;

   logic                              res_valid;
   logic                              res_ready;
   rtal_pkg::result_type              res;

   logic                              rsp_valid_ff, rsp_valid_in;
   rtal_pkg::result_type              rsp_ff, rsp_in;

   assign range_start  = req_tdata[31:0];
   assign range_end    = req_tdata[63:32];
   assign alpha_code   = req_tdata[71:64];
   assign lookup_value = req_tdata[103:72];

   // The alpha is fixed when the range is appended, from the registers then.
   assign alpha_value = rtal_pkg::code_to_alpha(alpha_code, quarter_ff, half_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         blend_ff   <= 1'b0;
         quarter_ff <= rtal_pkg::QUARTER_RESET;
         half_ff    <= rtal_pkg::HALF_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            rtal_pkg::REG_ENABLE:  blend_ff   <= csr_wdata[0];
            rtal_pkg::REG_QUARTER: quarter_ff <= csr_wdata;
            rtal_pkg::REG_HALF:    half_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   rtal_ram #(
      .WIDTH (rtal_pkg::WORD_W),
      .DEPTH (ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   rtal_ctrl #(
      .ENTRIES (ENTRIES)
   ) u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_tvalid),
      .req_ready    (req_tready),
      .op           (req_tuser),
      .range_start  (range_start),
      .range_end    (range_end),
      .alpha_value  (alpha_value),
      .lookup_value (lookup_value),
      .blend_enable (blend_ff),
      .rd_addr      (rd_addr),
      .rd_data      (rd_data),
      .wr_en        (wr_en),
      .wr_addr      (wr_addr),
      .wr_data      (wr_data),
      .res_valid    (res_valid),
      .res_ready    (res_ready),
      .res          (res)
   );

   // Output word register: the controller hands over when it is empty or draining.
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_in       = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_ff.alpha;
   assign rsp_tuser  = rsp_ff.status;

   // The table is written only while a command is being worked on.
   a_write_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> !req_tready)
      else $error("table write while idle");

   // A finished result and a free input port never coincide.
   a_result_busy: assert property (@(posedge clock) disable iff (reset)
      !(res_valid && req_tready))
      else $error("result pending while accepting");

   // An accepted word blocks the input in the cycle after the accept.
   a_accept_blocks: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input stayed open after accept");

   // A handed-over result shows up on the output in the next cycle.
   a_handover: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res_ready) |=> (rsp_tvalid && rsp_tuser == $past(res.status)))
      else $error("result lost at the output register");

endmodule

// ===== rtl/rtal_ram.sv =====
module rtal_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/rtal_ctrl.sv =====
module rtal_ctrl #(
   parameter int unsigned ENTRIES = rtal_pkg::DEFAULT_ENTRIES,
   localparam int unsigned IW = $clog2(ENTRIES),
   localparam int unsigned CW = IW + 1
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [1:0]                       op,
   input  logic [rtal_pkg::CODE_W-1:0]      range_start,
   input  logic [rtal_pkg::CODE_W-1:0]      range_end,
   input  logic [rtal_pkg::ALPHA_W-1:0]     alpha_value,
   input  logic [rtal_pkg::CODE_W-1:0]      lookup_value,
   input  logic                             blend_enable,
   output logic [IW-1:0]                    rd_addr,
   input  logic [rtal_pkg::WORD_W-1:0]      rd_data,
   output logic                             wr_en,
   output logic [IW-1:0]                    wr_addr,
   output logic [rtal_pkg::WORD_W-1:0]      wr_data,
   output logic                             res_valid,
   input  logic                             res_ready,
   output rtal_pkg::result_type             res
);

   typedef enum logic [1:0] {S_IDLE, S_APPEND, S_PROBE, S_DONE} state_type;

   state_type                        state_ff, state_in;
   logic [CW-1:0]                    count_ff, count_in;
   logic [CW-1:0]                    lo_ff, lo_in;
   logic [CW-1:0]                    hi_ff, hi_in;      // exclusive upper bound
   logic [IW-1:0]                    mid_ff, mid_in;
   logic [rtal_pkg::CODE_W-1:0]      start_ff, start_in;
   logic [rtal_pkg::CODE_W-1:0]      end_ff, end_in;
   logic [rtal_pkg::ALPHA_W-1:0]     alpha_ff, alpha_in;
   logic [rtal_pkg::CODE_W-1:0]      value_ff, value_in;
   rtal_pkg::result_type             res_ff, res_in;

   logic [rtal_pkg::CODE_W-1:0]      rd_start;
   logic [rtal_pkg::CODE_W-1:0]      rd_end;
   logic [rtal_pkg::ALPHA_W-1:0]     rd_alpha;
   logic [CW-1:0]                    count_m1;
   logic [CW-1:0]                    nlo;
   logic [CW-1:0]                    nhi;
   logic [CW:0]                      span_m1;
   logic [CW:0]                      first_m1;

   assign rd_start = rd_data[rtal_pkg::CODE_W-1:0];
   assign rd_end   = rd_data[2*rtal_pkg::CODE_W-1:rtal_pkg::CODE_W];
   assign rd_alpha = rd_data[rtal_pkg::WORD_W-1:2*rtal_pkg::CODE_W];
   assign count_m1 = count_ff - CW'(1);

   assign req_ready = (state_ff == S_IDLE);
   assign res_valid = (state_ff == S_DONE);
   assign res       = res_ff;

   assign wr_addr = count_ff[IW-1:0];
   assign wr_data = {alpha_ff, end_ff, start_ff};

   // Next search window after a probe that missed at mid_ff.
   always_comb begin
      if (value_ff < rd_start) begin
         nlo = lo_ff;
         nhi = CW'(mid_ff);
      end else begin
         nlo = CW'(mid_ff) + CW'(1);
         nhi = hi_ff;
      end
   end

   // Midpoint floor((lo + hi_incl) / 2) with hi_incl = hi - 1.
   assign span_m1  = (CW+1)'(nlo) + (CW+1)'(nhi) - (CW+1)'(1);
   assign first_m1 = (CW+1)'(count_ff) - (CW+1)'(1);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      mid_in   = mid_ff;
      start_in = start_ff;
      end_in   = end_ff;
      alpha_in = alpha_ff;
      value_in = value_ff;
      res_in   = res_ff;
      rd_addr  = mid_ff;
      wr_en    = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               start_in = range_start;
               end_in   = range_end;
               alpha_in = alpha_value;
               value_in = lookup_value;
               res_in   = '{alpha: '0, status: rtal_pkg::ST_OK};
               unique case (op)
                  rtal_pkg::OP_CLEAR: begin
                     count_in = '0;
                     state_in = S_DONE;
                  end
                  rtal_pkg::OP_APPEND: begin
                     rd_addr  = count_m1[IW-1:0];
                     state_in = S_APPEND;
                  end
                  rtal_pkg::OP_LOOKUP: begin
                     if (!blend_enable || count_ff == '0) begin
                        res_in.status = rtal_pkg::ST_MISS;
                        state_in      = S_DONE;
                     end else begin
                        lo_in    = '0;
                        hi_in    = count_ff;
                        mid_in   = first_m1[IW:1];
                        rd_addr  = first_m1[IW:1];
                        state_in = S_PROBE;
                     end
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_APPEND: begin
            // The previous start is on the read port now.
            if (count_ff != '0 && rd_start == start_ff) begin
               res_in.status = rtal_pkg::ST_DUP;
            end else if (count_ff == CW'(ENTRIES)) begin
               res_in.status = rtal_pkg::ST_FULL;
            end else begin
               wr_en    = 1'b1;
               count_in = count_ff + CW'(1);
            end
            state_in = S_DONE;
         end
         S_PROBE: begin
            if (rd_start <= value_ff && rd_end >= value_ff) begin
               res_in   = '{alpha: rd_alpha, status: rtal_pkg::ST_OK};
               state_in = S_DONE;
            end else if (nlo < nhi) begin
               lo_in   = nlo;
               hi_in   = nhi;
               mid_in  = span_m1[IW:1];
               rd_addr = span_m1[IW:1];
            end else begin
               res_in.status = rtal_pkg::ST_MISS;
               state_in      = S_DONE;
            end
         end
         S_DONE: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      mid_ff   <= mid_in;
      start_ff <= start_in;
      end_ff   <= end_in;
      alpha_ff <= alpha_in;
      value_ff <= value_in;
      res_ff   <= res_in;
   end

endmodule
